### design/apfs_pkg.sv
// ----------------------------------------------------------------------------
// apfs_pkg
// Shared types and constants of the active particle force step block.
// ----------------------------------------------------------------------------
package apfs_pkg;

   localparam int PARTICLES_DEF    = 1024;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int IDX_W            = 10;

   localparam logic [2:0] MODE_BROWNIAN = 3'd0;
   localparam logic [2:0] MODE_CHIRAL   = 3'd1;
   localparam logic [2:0] MODE_TUMBLE   = 3'd2;
   localparam logic [2:0] MODE_OU       = 3'd3;
   localparam logic [2:0] MODE_SPINNER  = 3'd4;

   localparam logic [2:0] REG_MODE   = 3'd0;
   localparam logic [2:0] REG_DRIVE  = 3'd1;
   localparam logic [2:0] REG_ROT    = 3'd2;
   localparam logic [2:0] REG_OMEGA  = 3'd3;
   localparam logic [2:0] REG_TUMBLE = 3'd4;
   localparam logic [2:0] REG_DECAY  = 3'd5;
   localparam logic [2:0] REG_GAIN   = 3'd6;
   localparam logic [2:0] REG_TRANS  = 3'd7;

   localparam logic OP_STEP = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_CALC, ST_CORDIC, ST_MUL, ST_SUM, ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic [31:0] angle;
   } cordic_req_type;

   typedef struct packed {
      logic done;
      logic signed [33:0] cos_v;
      logic signed [33:0] sin_v;
   } cordic_rsp_type;

   function automatic logic [31:0] atan_turn(input logic [4:0] i);
      unique case (i)
         5'd0:  atan_turn = 32'h20000000;
         5'd1:  atan_turn = 32'h12E4051D;
         5'd2:  atan_turn = 32'h09FB385B;
         5'd3:  atan_turn = 32'h051111D4;
         5'd4:  atan_turn = 32'h028B0D43;
         5'd5:  atan_turn = 32'h0145D7E1;
         5'd6:  atan_turn = 32'h00A2F61E;
         5'd7:  atan_turn = 32'h00517C55;
         5'd8:  atan_turn = 32'h0028BE53;
         5'd9:  atan_turn = 32'h00145F2E;
         5'd10: atan_turn = 32'h000A2F98;
         5'd11: atan_turn = 32'h000517CC;
         5'd12: atan_turn = 32'h00028BE6;
         5'd13: atan_turn = 32'h000145F3;
         5'd14: atan_turn = 32'h0000A2F9;
         5'd15: atan_turn = 32'h0000517C;
         5'd16: atan_turn = 32'h000028BE;
         5'd17: atan_turn = 32'h0000145F;
         5'd18: atan_turn = 32'h00000A2F;
         5'd19: atan_turn = 32'h00000517;
         5'd20: atan_turn = 32'h0000028B;
         5'd21: atan_turn = 32'h00000145;
         5'd22: atan_turn = 32'h000000A2;
         5'd23: atan_turn = 32'h00000051;
         5'd24: atan_turn = 32'h00000028;
         5'd25: atan_turn = 32'h00000014;
         5'd26: atan_turn = 32'h0000000A;
         5'd27: atan_turn = 32'h00000005;
         5'd28: atan_turn = 32'h00000002;
         5'd29: atan_turn = 32'h00000001;
         default: atan_turn = 32'h0;
      endcase
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647)
         sat32 = 32'sh7FFFFFFF;
      else if (v < -66'sd2147483648)
         sat32 = 32'sh80000000;
      else
         sat32 = v[31:0];
   endfunction

endpackage

### design/apfs_cordic.sv
// ----------------------------------------------------------------------------
// apfs_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module apfs_cordic #(
   parameter int CORDIC_STEPS = apfs_pkg::CORDIC_STEPS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  apfs_pkg::cordic_req_type req,
   output apfs_pkg::cordic_rsp_type rsp
);
   import apfs_pkg::*;

   localparam logic [4:0] LAST = 5'(CORDIC_STEPS - 1);

   logic               busy_ff, busy_in;
   logic               flip_ff, flip_in;
   logic [4:0]         step_ff, step_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in;
   logic signed [33:0] z_ff, z_in;
   logic signed [33:0] xs, ys;
   logic               done_ff, done_in;

   always_comb begin
      busy_in = busy_ff;
      flip_in = flip_ff;
      step_in = step_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      done_in = 1'b0;
      xs      = x_ff >>> step_ff;
      ys      = y_ff >>> step_ff;
      if (req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         x_in    = CORDIC_X0;
         y_in    = '0;
         if (req.angle >= 32'h40000000 && req.angle < 32'hC0000000) begin
            flip_in = 1'b1;
            z_in    = 34'(signed'({2'b00, req.angle})) - 34'sh080000000;
         end else begin
            flip_in = 1'b0;
            z_in    = 34'(signed'(req.angle));
         end
      end else if (busy_ff) begin
         if (!z_ff[33]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - 34'(atan_turn(step_ff));
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + 34'(atan_turn(step_ff));
         end
         step_in = step_ff + 5'd1;
         if (step_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      flip_ff <= flip_in;
      step_ff <= step_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.cos_v = flip_ff ? -x_ff : x_ff;
   assign rsp.sin_v = flip_ff ? -y_ff : y_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("cordic done without busy");
   a_idle_after_done: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("cordic busy after done");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !done_ff |-> !req.start || !busy_ff)
      else $error("cordic restarted while busy");

endmodule

### design/active_particle_force_step.sv
// ----------------------------------------------------------------------------
// active_particle_force_step
// Per-particle self-propulsion force unit for active particles.
// ----------------------------------------------------------------------------
// Items enter on req_ (tvalid/tready/tdata/tuser); one result per item leaves
// on rsp_. The user must make csr_ writes of mode and coefficients only while
// the block is idle; the block itself does not enforce this. One item at a
// time: the heading and OU velocity memories are read in the READ state, then
// the step is computed. Loads, out-of-group and out-of-range items pass READ,
// CALC and OUT; OU and spinner steps pass READ, CALC, SUM and OUT; CORDIC
// mode steps pass READ, CALC, CORDIC, MUL, SUM and OUT, where the iterative
// CORDIC does one micro-rotation per cycle. req_tready returns in the same
// cycle as the result becomes valid in the rsp_ register.
// While a result waits in the rsp_ register the block still takes one item
// and holds its result in the last stage until the waiting one is taken.
// Synchronous reset clears state, rsp_tvalid and csr_ registers to defaults;
// datapath registers are not reset; memory contents are undefined until loaded.
// Particle indices at or above PARTICLES give zero force and zero heading.
// ----------------------------------------------------------------------------
module active_particle_force_step #(
   parameter int PARTICLES    = apfs_pkg::PARTICLES_DEF,
   parameter int CORDIC_STEPS = apfs_pkg::CORDIC_STEPS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // particle, in_group, gauss_one, gauss_two, gauss_three, uniform_one,
   // uniform_two, vel_x, vel_y, load_a, load_b, zero pad
   input  logic [223:0] req_tdata,
   // operation
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // force_x, force_y, heading
   output logic [95:0]  rsp_tdata,
   input  logic         csr_wen,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);
   import apfs_pkg::*;

   localparam int AW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;

   logic [2:0]         mode_ff;
   logic signed [31:0] drive_ff, omega_ff;
   logic [31:0]        rot_ff;
   logic [16:0]        tumble_ff, decay_ff;
   logic [30:0]        gain_ff, trans_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_BROWNIAN;
         drive_ff  <= 32'sd65536;
         rot_ff    <= '0;
         omega_ff  <= '0;
         tumble_ff <= '0;
         decay_ff  <= 17'd65536;
         gain_ff   <= '0;
         trans_ff  <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            REG_MODE:   mode_ff   <= csr_wdata[2:0];
            REG_DRIVE:  drive_ff  <= csr_wdata;
            REG_ROT:    rot_ff    <= csr_wdata;
            REG_OMEGA:  omega_ff  <= csr_wdata;
            REG_TUMBLE: tumble_ff <= csr_wdata[16:0];
            REG_DECAY:  decay_ff  <= csr_wdata[16:0];
            REG_GAIN:   gain_ff   <= csr_wdata[30:0];
            REG_TRANS:  trans_ff  <= csr_wdata[30:0];
            default:    ;
         endcase
      end
   end

   // item fields
   logic               op_ff, grp_ff, valid_p_ff;
   logic [IDX_W-1:0]   p_ff;
   logic signed [15:0] g1_ff, g2_ff, g3_ff;
   logic [15:0]        u1_ff, u2_ff;
   logic signed [31:0] vx_ff, vy_ff, la_ff, lb_ff;

   state_type state_ff, state_in;

   logic [31:0] heading_mem [PARTICLES];
   logic [31:0] ouvx_mem [PARTICLES];
   logic [31:0] ouvy_mem [PARTICLES];
   logic [31:0] h_rd_ff, vx_rd_ff, vy_rd_ff;
   logic        wr_h, wr_ou;
   logic [31:0] wr_h_data, wr_vx_data, wr_vy_data;
   logic [AW-1:0] addr;

   assign addr = p_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (wr_h)  heading_mem[addr] <= wr_h_data;
      if (wr_ou) begin
         ouvx_mem[addr] <= wr_vx_data;
         ouvy_mem[addr] <= wr_vy_data;
      end
      h_rd_ff  <= heading_mem[addr];
      vx_rd_ff <= ouvx_mem[addr];
      vy_rd_ff <= ouvy_mem[addr];
   end

   logic req_fire, rsp_fire, out_load;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign out_load   = (state_ff == ST_OUT) && (!rsp_tvalid || rsp_tready);

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff      <= req_tuser;
         p_ff       <= req_tdata[9:0];
         valid_p_ff <= 32'(req_tdata[9:0]) < PARTICLES;
         grp_ff     <= req_tdata[10];
         g1_ff      <= req_tdata[26:11];
         g2_ff      <= req_tdata[42:27];
         g3_ff      <= req_tdata[58:43];
         u1_ff      <= req_tdata[74:59];
         u2_ff      <= req_tdata[90:75];
         vx_ff      <= req_tdata[122:91];
         vy_ff      <= req_tdata[154:123];
         la_ff      <= req_tdata[186:155];
         lb_ff      <= req_tdata[218:187];
      end
   end

   // arithmetic registers
   logic [31:0]        h_new_ff, h_new_in;
   logic signed [65:0] pa_ff, pa_in, pb_ff, pb_in;
   logic signed [65:0] pc_ff, pc_in, pd_ff, pd_in;
   logic signed [31:0] fx_ff, fx_in, fy_ff, fy_in;
   logic [31:0]        hout_ff, hout_in;
   logic               cordic_mode;
   cordic_req_type     creq;
   cordic_rsp_type     crsp;

   apfs_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .req(creq), .rsp(crsp)
   );

   assign cordic_mode = !(mode_ff == MODE_OU || mode_ff == MODE_SPINNER);

   logic signed [17:0] dec;
   logic signed [49:0] rot_prod;
   logic [31:0]        h_calc;
   assign dec = (decay_ff > 17'd65536) ? 18'sd65536 : signed'({1'b0, decay_ff});
   assign rot_prod = signed'({1'b0, rot_ff}) * g1_ff;

   always_comb begin
      h_calc = h_rd_ff;
      if (mode_ff == MODE_TUMBLE) begin
         if ({1'b0, u1_ff} < tumble_ff) h_calc = {u2_ff, 16'h0};
      end else begin
         h_calc = h_rd_ff + 32'((rot_prod + 50'sd2048) >>> 12);
         if (mode_ff == MODE_CHIRAL) h_calc = h_calc + omega_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_READ;
         ST_READ:   state_in = ST_CALC;
         ST_CALC: begin
            if (!valid_p_ff || op_ff == OP_LOAD || !grp_ff) state_in = ST_OUT;
            else if (cordic_mode) state_in = ST_CORDIC;
            else state_in = ST_SUM;
         end
         ST_CORDIC: if (crsp.done) state_in = ST_MUL;
         ST_MUL:    state_in = ST_SUM;
         ST_SUM:    state_in = ST_OUT;
         ST_OUT:    if (out_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      h_new_in   = h_new_ff;
      pa_in      = pa_ff;
      pb_in      = pb_ff;
      pc_in      = pc_ff;
      pd_in      = pd_ff;
      fx_in      = fx_ff;
      fy_in      = fy_ff;
      hout_in    = hout_ff;
      wr_h       = 1'b0;
      wr_ou      = 1'b0;
      wr_h_data  = la_ff;
      wr_vx_data = la_ff;
      wr_vy_data = lb_ff;
      creq.start = 1'b0;
      creq.angle = h_new_ff;
      unique case (state_ff)
         ST_CALC: begin
            fx_in   = '0;
            fy_in   = '0;
            hout_in = h_rd_ff;
            if (!valid_p_ff) begin
               hout_in = '0;
            end else if (op_ff == OP_LOAD) begin
               if (mode_ff == MODE_OU) wr_ou = 1'b1;
               else begin
                  wr_h    = 1'b1;
                  hout_in = la_ff;
               end
            end else if (grp_ff) begin
               if (mode_ff == MODE_OU) begin
                  pa_in = 66'(dec * signed'(vx_rd_ff));
                  pb_in = 66'(dec * signed'(vy_rd_ff));
                  pc_in = 66'(signed'({1'b0, gain_ff}) * g1_ff);
                  pd_in = 66'(signed'({1'b0, gain_ff}) * g2_ff);
               end else if (mode_ff == MODE_SPINNER) begin
                  pa_in = 66'(-(66'(drive_ff) * 66'(vy_ff)));
                  pb_in = 66'(66'(drive_ff) * 66'(vx_ff));
                  pc_in = '0;
                  pd_in = '0;
               end else begin
                  h_new_in   = h_calc;
                  hout_in    = h_calc;
                  wr_h       = 1'b1;
                  wr_h_data  = h_calc;
                  creq.start = 1'b1;
                  creq.angle = h_calc;
                  if (mode_ff == MODE_CHIRAL || mode_ff == MODE_TUMBLE) begin
                     pc_in = '0;
                     pd_in = '0;
                  end else begin
                     pc_in = 66'(signed'({1'b0, trans_ff}) * g2_ff);
                     pd_in = 66'(signed'({1'b0, trans_ff}) * g3_ff);
                  end
               end
            end
         end
         ST_MUL: begin
            pa_in = 66'(66'(drive_ff) * crsp.cos_v);
            pb_in = 66'(66'(drive_ff) * crsp.sin_v);
         end
         ST_SUM: begin
            if (mode_ff == MODE_OU) begin
               fx_in = sat32(((pa_ff + 66'sd32768) >>> 16) + ((pc_ff + 66'sd2048) >>> 12));
               fy_in = sat32(((pb_ff + 66'sd32768) >>> 16) + ((pd_ff + 66'sd2048) >>> 12));
               wr_ou      = 1'b1;
               wr_vx_data = fx_in;
               wr_vy_data = fy_in;
            end else if (mode_ff == MODE_SPINNER) begin
               fx_in = sat32((pa_ff + 66'sd32768) >>> 16);
               fy_in = sat32((pb_ff + 66'sd32768) >>> 16);
            end else begin
               fx_in = sat32(((pa_ff + 66'sd536870912) >>> 30)
                             + ((pc_ff + 66'sd2048) >>> 12));
               fy_in = sat32(((pb_ff + 66'sd536870912) >>> 30)
                             + ((pd_ff + 66'sd2048) >>> 12));
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rsp_tvalid <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) rsp_tvalid <= 1'b1;
         else if (rsp_fire) rsp_tvalid <= 1'b0;
      end
      h_new_ff <= h_new_in;
      pa_ff    <= pa_in;
      pb_ff    <= pb_in;
      pc_ff    <= pc_in;
      pd_ff    <= pd_in;
      fx_ff    <= fx_in;
      fy_ff    <= fy_in;
      hout_ff  <= hout_in;
      if (out_load) rsp_tdata <= {hout_ff, fy_ff, fx_ff};
   end

   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == ST_IDLE) else $error("ready outside idle");
   a_out_then_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |=> rsp_tvalid) else $error("result lost");
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !wr_h && !wr_ou) else $error("stray memory write");
   a_fire_to_read: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_READ) else $error("accept did not start read");

endmodule
